### hdl/dskt_pkg.sv
// Shared types and constants for the deadline sorted keyed table.
// Entry layout, result record, status codes and register indexes.
// No dependencies.
package dskt_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned TYPE_W     = 4;
  localparam int unsigned NUM_W      = 8;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned DATE_W     = MONTH_W + DAY_W;
  localparam int unsigned KEY_W      = TYPE_W + NUM_W;
  localparam int unsigned ENTRY_W    = KEY_W + DATE_W;
  localparam int unsigned STATUS_W   = 3;

  localparam int unsigned IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned RES_W       = STATUS_W + IDX_W + CNT_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - RES_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE = 1'd1;

  localparam logic [CNT_W-1:0] CAPACITY_RST = 5'd4;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SET       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_ON_TIME   = 3'd3,
    ST_OVERDUE   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef struct packed {
    logic [TYPE_W-1:0]  task_type;
    logic [NUM_W-1:0]   task_number;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   position;
    logic [CNT_W-1:0]   occupancy;
  } result_t;

endpackage

### hdl/dskt_out_reg.sv
// Output register for the deadline sorted keyed table result stream.
// Holds one result until the downstream side takes it.
// Depends on dskt_pkg.
module dskt_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  dskt_pkg::result_t                  res_i,
  output logic                               ready_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[2:0], position[6:3], occupancy[11:7], zero pad
  output logic [dskt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic              valid_q;
  dskt_pkg::result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{dskt_pkg::OUT_PAD_W{1'b0}}, res_q.occupancy, res_q.position,
                          res_q.status};

endmodule

### hdl/deadline_sorted_keyed_table.sv
// Top level of the deadline sorted keyed table: entry memory and sequencer.
// Depends on dskt_pkg and dskt_out_reg.
//
//  channel  | signals                                   | transaction
//  ---------+-------------------------------------------+------------------------
//  input    | s_axis_tvalid/tready/tdata/tuser          | one update or finish
//  result   | m_axis_tvalid/tready/tdata                | one result per input
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i           | one write per cycle
//
// One item at a time. The key search reads and checks one entry per step; each
// shift step of a sorted move or a removal reads, then writes back through the
// single-port-pair memory. A rejected or missing key skips the writes; a sorted
// move adds date checks. An item may also wait for the output register.
// Reset clears the count and the registers only; no clearing pass.
// A stalled result waits in the output register; the next item is taken meanwhile.
module deadline_sorted_keyed_table (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // task_type[3:0], task_number[11:4], month[15:12], day[20:16], zero pad
  input  logic [dskt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind[0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status[2:0], position[6:3], occupancy[11:7], zero pad
  output logic [dskt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [dskt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dskt_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W  = dskt_pkg::IDX_W;
  localparam int unsigned CNT_W  = dskt_pkg::CNT_W;
  localparam int unsigned DATE_W = dskt_pkg::DATE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DECIDE,
    S_DIR_RD,
    S_DIR_CHK,
    S_RIGHT_RD,
    S_RIGHT_CHK,
    S_LEFT_RD,
    S_LEFT_CHK,
    S_FINAL,
    S_REM_RD,
    S_REM_CHK,
    S_DONE
  } state_e;

  // configuration
  logic [CNT_W-1:0] capacity_q;
  logic             sorted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= dskt_pkg::CAPACITY_RST;
      sorted_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dskt_pkg::REG_CAPACITY:    capacity_q <= cfg_data_i[CNT_W-1:0];
        dskt_pkg::REG_SORTED_MODE: sorted_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // entry memory
  dskt_pkg::entry_t mem [dskt_pkg::DEPTH];
  dskt_pkg::entry_t rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  dskt_pkg::entry_t mem_wd;
  logic [IDX_W-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_addr];
  end

  // sequencer state
  state_e            state_q;
  dskt_pkg::entry_t  item_q;
  logic              kind_q;
  logic [CNT_W-1:0]  cur_q;
  logic [CNT_W-1:0]  count_q;
  logic              found_q;
  logic [DATE_W-1:0] old_date_q;
  dskt_pkg::result_t res_q;

  logic [CNT_W-1:0]  cur_nxt;
  logic [CNT_W-1:0]  cur_prv;
  logic [CNT_W-1:0]  cap;
  logic [DATE_W-1:0] new_date;
  logic [DATE_W-1:0] rd_date;
  logic              key_hit;
  logic              out_ready;
  logic              push;

  assign cur_nxt  = cur_q + CNT_W'(1);
  assign cur_prv  = cur_q - CNT_W'(1);
  assign cap      = (capacity_q > CNT_W'(dskt_pkg::DEPTH)) ? CNT_W'(dskt_pkg::DEPTH)
                                                           : capacity_q;
  assign new_date = {item_q.month, item_q.day};
  assign rd_date  = {rdata_q.month, rdata_q.day};
  assign key_hit  = (rdata_q.task_type == item_q.task_type) &&
                    (rdata_q.task_number == item_q.task_number);
  assign push     = (state_q == S_DONE);
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = cur_q[IDX_W-1:0];
    mem_wd  = rdata_q;
    rd_addr = cur_q[IDX_W-1:0];
    case (state_q)
      S_DIR_RD, S_RIGHT_RD, S_REM_RD: rd_addr = cur_nxt[IDX_W-1:0];
      S_LEFT_RD:   rd_addr = cur_prv[IDX_W-1:0];
      S_DIR_CHK:   mem_we  = !(new_date < rd_date);
      S_RIGHT_CHK: mem_we  = (rd_date <= new_date);
      S_LEFT_CHK:  mem_we  = (rd_date > new_date);
      S_REM_CHK:   mem_we  = 1'b1;
      S_FINAL: begin
        mem_we = 1'b1;
        mem_wd = item_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      cur_q      <= '0;
      found_q    <= 1'b0;
      kind_q     <= dskt_pkg::KIND_UPDATE;
      item_q     <= '0;
      old_date_q <= '0;
      res_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            item_q.task_type   <= s_axis_tdata[3:0];
            item_q.task_number <= s_axis_tdata[11:4];
            item_q.month       <= s_axis_tdata[15:12];
            item_q.day         <= s_axis_tdata[20:16];
            kind_q  <= s_axis_tuser;
            cur_q   <= '0;
            found_q <= 1'b0;
            state_q <= (count_q == '0) ? S_DECIDE : S_SRCH_RD;
          end
        end
        S_SRCH_RD: state_q <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (key_hit) begin
            found_q    <= 1'b1;
            old_date_q <= rd_date;
            state_q    <= S_DECIDE;
          end else begin
            cur_q   <= cur_nxt;
            state_q <= (cur_nxt == count_q) ? S_DECIDE : S_SRCH_RD;
          end
        end
        S_DECIDE: begin
          if (kind_q == dskt_pkg::KIND_UPDATE) begin
            if (!found_q) begin
              if (count_q >= cap) begin
                res_q.status    <= dskt_pkg::ST_FULL;
                res_q.position  <= '0;
                res_q.occupancy <= count_q;
                state_q         <= S_DONE;
              end else begin
                count_q      <= count_q + CNT_W'(1);
                res_q.status <= dskt_pkg::ST_ADDED;
                state_q      <= sorted_q ? S_LEFT_RD : S_FINAL;
              end
            end else begin
              res_q.status <= dskt_pkg::ST_SET;
              if (sorted_q && (old_date_q != new_date)) begin
                state_q <= (cur_nxt == count_q) ? S_LEFT_RD : S_DIR_RD;
              end else begin
                state_q <= S_FINAL;
              end
            end
          end else begin
            if (!found_q) begin
              res_q.status    <= dskt_pkg::ST_NOT_FOUND;
              res_q.position  <= '0;
              res_q.occupancy <= count_q;
              state_q         <= S_DONE;
            end else begin
              res_q.status    <= (new_date > old_date_q) ? dskt_pkg::ST_OVERDUE
                                                         : dskt_pkg::ST_ON_TIME;
              res_q.position  <= cur_q[IDX_W-1:0];
              res_q.occupancy <= count_q - CNT_W'(1);
              count_q         <= count_q - CNT_W'(1);
              state_q         <= S_REM_RD;
            end
          end
        end
        S_DIR_RD: state_q <= S_DIR_CHK;
        S_DIR_CHK: begin
          if (new_date < rd_date) begin
            state_q <= S_LEFT_RD;
          end else begin
            cur_q   <= cur_nxt;
            state_q <= S_RIGHT_RD;
          end
        end
        S_RIGHT_RD: state_q <= (cur_nxt >= count_q) ? S_FINAL : S_RIGHT_CHK;
        S_RIGHT_CHK: begin
          if (rd_date <= new_date) begin
            cur_q   <= cur_nxt;
            state_q <= S_RIGHT_RD;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_LEFT_RD: state_q <= (cur_q == '0) ? S_FINAL : S_LEFT_CHK;
        S_LEFT_CHK: begin
          if (rd_date > new_date) begin
            cur_q   <= cur_prv;
            state_q <= S_LEFT_RD;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          res_q.position  <= cur_q[IDX_W-1:0];
          res_q.occupancy <= count_q;
          state_q         <= S_DONE;
        end
        S_REM_RD: state_q <= (cur_q >= count_q) ? S_DONE : S_REM_CHK;
        S_REM_CHK: begin
          cur_q   <= cur_nxt;
          state_q <= S_REM_RD;
        end
        S_DONE: begin
          if (out_ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  dskt_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res_q),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### hdl/dskt_checker.sv
// Port-level checks for the deadline sorted keyed table result stream.
// Bound to deadline_sorted_keyed_table; depends on dskt_pkg.
module dskt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dskt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic [2:0] status;
  logic [3:0] position;
  logic [4:0] occupancy;

  assign status    = m_axis_tdata[2:0];
  assign position  = m_axis_tdata[6:3];
  assign occupancy = m_axis_tdata[11:7];

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status <= dskt_pkg::ST_NOT_FOUND) &&
                      (occupancy <= 5'(dskt_pkg::DEPTH)))
    else $error("result status or occupancy out of range");

  a_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == dskt_pkg::ST_FULL || status == dskt_pkg::ST_NOT_FOUND)
      |-> (position == '0))
    else $error("rejected or missing entry reports a nonzero slot");

  a_held_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == dskt_pkg::ST_SET || status == dskt_pkg::ST_ADDED)
      |-> (5'(position) < occupancy))
    else $error("updated entry slot beyond occupancy");

  a_removed_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == dskt_pkg::ST_ON_TIME || status == dskt_pkg::ST_OVERDUE)
      |-> (5'(position) <= occupancy) && (occupancy < 5'(dskt_pkg::DEPTH)))
    else $error("removed entry slot beyond previous occupancy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind deadline_sorted_keyed_table dskt_checker u_dskt_checker (.*);

### bench/deadline_sorted_keyed_table_checker.sv
// Checker for the deadline sorted keyed table: watches the input, result and
// register write channels, predicts each result and compares field by field.
// Depends on dskt_pkg.
module deadline_sorted_keyed_table_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // task_type[3:0], task_number[11:4], month[15:12], day[20:16], zero pad
  input  logic [dskt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0], position[6:3], occupancy[11:7], zero pad
  input  logic [dskt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [dskt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dskt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                errors_o,
  output int                                pending_o
);
  import dskt_pkg::*;

  entry_t           slots [DEPTH];
  int unsigned      held;
  logic [CNT_W-1:0] cap_reg;
  logic             sort_reg;
  result_t          outcome_q [$];

  function automatic logic [DATE_W-1:0] due_date(entry_t e);
    return {e.month, e.day};
  endfunction

  function automatic result_t table_apply(logic kind, entry_t item);
    logic [KEY_W-1:0]  key;
    logic [DATE_W-1:0] date;
    int unsigned       i;
    int unsigned       lim;
    bit                added;
    bit                changed;
    result_t           r;
    key        = {item.task_type, item.task_number};
    date       = due_date(item);
    r.status   = ST_SET;
    r.position = '0;
    added      = 1'b0;
    changed    = 1'b0;
    i          = 0;
    while (i < held && {slots[i].task_type, slots[i].task_number} != key) i++;
    if (kind == KIND_UPDATE) begin
      lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
      if (i == held) begin
        if (held >= lim) begin
          r.status    = ST_FULL;
          r.occupancy = CNT_W'(held);
          return r;
        end
        held++;
        added    = 1'b1;
        r.status = ST_ADDED;
      end else begin
        changed = due_date(slots[i]) != date;
      end
      slots[i] = item;
      if (sort_reg && (added || changed)) begin
        if (added || i + 1 == held || date < due_date(slots[i+1])) begin
          // move toward the head past strictly later dates
          while (i > 0 && due_date(slots[i-1]) > date) begin
            slots[i] = slots[i-1];
            i--;
          end
        end else begin
          // move toward the tail past dates not later than this one
          while (i + 1 < held && due_date(slots[i+1]) <= date) begin
            slots[i] = slots[i+1];
            i++;
          end
        end
        slots[i] = item;
      end
      r.position = IDX_W'(i);
    end else if (i == held) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.status   = (date > due_date(slots[i])) ? ST_OVERDUE : ST_ON_TIME;
      r.position = IDX_W'(i);
      held--;
      for (; i < held; i++) slots[i] = slots[i+1];
    end
    r.occupancy = CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t  item;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      held     = 0;
      cap_reg  = CAPACITY_RST;
      sort_reg = 1'b0;
      for (int k = 0; k < DEPTH; k++) slots[k] = '0;
      outcome_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CAPACITY) cap_reg = cfg_data_i;
        else if (cfg_idx_i == REG_SORTED_MODE) sort_reg = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item.task_type   = s_axis_tdata[3:0];
        item.task_number = s_axis_tdata[11:4];
        item.month       = s_axis_tdata[15:12];
        item.day         = s_axis_tdata[20:16];
        outcome_q.push_back(table_apply(s_axis_tuser, item));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = status_e'(m_axis_tdata[2:0]);
        got.position  = m_axis_tdata[6:3];
        got.occupancy = m_axis_tdata[11:7];
        if (outcome_q.size() == 0) begin
          $display("%0t: result expected none, got status %0d position %0d occupancy %0d",
                   $time, got.status, got.position, got.occupancy);
          errors_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors_o++;
          end
          if (got.position != want.position) begin
            $display("%0t: position expected %0d got %0d",
                     $time, want.position, got.position);
            errors_o++;
          end
          if (got.occupancy != want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d",
                     $time, want.occupancy, got.occupancy);
            errors_o++;
          end
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

### bench/deadline_sorted_keyed_table_tb.sv
// Testbench top for the deadline sorted keyed table: clock, reset, register
// writes, directed and random table events, result back-pressure and verdict.
// Depends on dskt_pkg, deadline_sorted_keyed_table and its checker module.
module deadline_sorted_keyed_table_tb;
  import dskt_pkg::*;

  localparam int unsigned POOL_N    = 20;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PER_PHASE = 192;
  localparam int unsigned PHASE_CAP  [PHASES] = '{16, 16, 1, 8, 31, 0, 12, 16};
  localparam bit          PHASE_SORT [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  int                      errors;
  int                      pending;
  logic                    hold_go;
  entry_t                  key_pool [POOL_N];

  deadline_sorted_keyed_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  deadline_sorted_keyed_table_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(8 * 900_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic entry_t mk(int unsigned ty, int unsigned num, int unsigned mo,
                                int unsigned dy);
    entry_t e;
    e.task_type   = TYPE_W'(ty);
    e.task_number = NUM_W'(num);
    e.month       = MONTH_W'(mo);
    e.day         = DAY_W'(dy);
    return e;
  endfunction

  function automatic entry_t rand_item();
    entry_t      e;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) begin
      e = key_pool[$urandom_range(POOL_N-1)];
    end else begin
      e.task_type   = TYPE_W'($urandom);
      e.task_number = NUM_W'($urandom);
    end
    r = $urandom_range(99);
    if (r < 50) begin
      // narrow date range, many equal dates
      e.month = MONTH_W'($urandom_range(2, 1));
      e.day   = DAY_W'($urandom_range(3, 1));
    end else if (r < 95) begin
      e.month = MONTH_W'($urandom_range(12, 1));
      e.day   = DAY_W'($urandom_range(31, 1));
    end else begin
      e.month = MONTH_W'($urandom_range(15, 0));
      e.day   = DAY_W'($urandom_range(31, 0));
    end
    return e;
  endfunction

  task automatic send_item(logic kind, entry_t e, bit may_idle);
    if (may_idle && $urandom_range(99) < 28) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid       = 1'b1;
    s_axis_tuser        = kind;
    s_axis_tdata        = '0;
    s_axis_tdata[20:0]  = {e.day, e.month, e.task_number, e.task_type};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // result side: random back-pressure, one long hold, one calm stretch
  initial begin
    int unsigned rcyc;
    int unsigned hold;
    bit          held_once;
    m_axis_tready = 1'b0;
    rcyc          = 0;
    hold          = 0;
    held_once     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rcyc++;
      if (hold_go && !held_once) begin
        held_once = 1'b1;
        hold      = 700;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if (rcyc >= 20000 && rcyc < 28000) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_UPDATE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_CAPACITY;
    cfg_data_i    = '0;
    hold_go       = 1'b0;
    n             = 0;
    key_pool[0]   = mk(0, 0, 1, 1);
    key_pool[1]   = mk(15, 255, 1, 1);
    for (int k = 2; k < POOL_N; k++) key_pool[k] = mk($urandom, $urandom, 1, 1);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: capacity 4, arrival order
    send_item(KIND_FINISH, mk(0, 0, 1, 1), 1'b0);
    send_item(KIND_UPDATE, mk(15, 255, 12, 31), 1'b0);
    send_item(KIND_UPDATE, mk(0, 0, 1, 1), 1'b0);
    send_item(KIND_UPDATE, mk(5, 17, 0, 0), 1'b0);
    send_item(KIND_UPDATE, mk(9, 200, 15, 31), 1'b0);
    send_item(KIND_UPDATE, mk(3, 3, 6, 6), 1'b0);
    send_item(KIND_UPDATE, mk(0, 0, 1, 1), 1'b0);
    drain();
    // sort a table that was filled in arrival order
    cfg_write(REG_SORTED_MODE, 5'b00001);
    send_item(KIND_UPDATE, mk(15, 255, 1, 1), 1'b0);
    send_item(KIND_UPDATE, mk(15, 255, 1, 1), 1'b0);
    send_item(KIND_UPDATE, mk(5, 17, 13, 0), 1'b0);
    drain();
    // capacity below the count
    cfg_write(REG_CAPACITY, 5'd2);
    send_item(KIND_UPDATE, mk(7, 7, 2, 2), 1'b0);
    send_item(KIND_FINISH, mk(9, 200, 1, 1), 1'b0);
    send_item(KIND_FINISH, mk(0, 0, 2, 1), 1'b0);
    send_item(KIND_UPDATE, mk(7, 7, 2, 2), 1'b0);
    drain();
    cfg_write(REG_CAPACITY, 5'd0);
    send_item(KIND_UPDATE, mk(1, 1, 1, 1), 1'b0);
    send_item(KIND_UPDATE, mk(5, 17, 1, 15), 1'b0);
    drain();
    cfg_write(REG_CAPACITY, 5'd31);
    send_item(KIND_UPDATE, mk(1, 1, 4, 4), 1'b0);
    send_item(KIND_UPDATE, mk(2, 2, 4, 4), 1'b0);
    send_item(KIND_UPDATE, mk(3, 3, 1, 1), 1'b0);
    send_item(KIND_FINISH, mk(1, 1, 4, 4), 1'b0);
    send_item(KIND_FINISH, mk(1, 1, 4, 4), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_write(REG_CAPACITY, CFG_DATA_W'(PHASE_CAP[p]));
      cfg_write(REG_SORTED_MODE, {4'($urandom_range(15)), PHASE_SORT[p]});
      if (p == 0) hold_go = 1'b1;
      for (int k = 0; k < PER_PHASE; k++) begin
        send_item(($urandom_range(99) < 40) ? KIND_FINISH : KIND_UPDATE, rand_item(),
                  !(n >= 300 && n < 550));
        n++;
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
